// File: design/q4k_pkg.sv
`timescale 1ns / 1ps

package q4k_pkg;

  localparam int unsigned BlockWords = 18;
  localparam logic [4:0] LastPos = 5'd17;
  localparam logic [31:0] DefaultNan = 32'hFFC00000;

  typedef logic [11:0][7:0] scale_t;

  // One nibble word with everything the back end needs for its two results.
  typedef struct packed {
    logic [63:0] word;
    logic [15:0] d_half;
    logic [15:0] dmin_half;
    logic [5:0]  sc_lo;
    logic [5:0]  mm_lo;
    logic [5:0]  sc_hi;
    logic [5:0]  mm_hi;
    logic [7:0]  pos_lo;
    logic        last;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  // Six-bit scale and min codes of sub-block j, returned as {sc, mm}.
  function automatic logic [11:0] sub_codes(scale_t s, logic [2:0] j);
    logic [5:0] sc;
    logic [5:0] mm;
    if (!j[2]) begin
      sc = s[j[1:0]][5:0];
      mm = s[{1'b0, j[1:0]} + 3'd4][5:0];
    end else begin
      sc = {s[j[1:0]][7:6], s[{1'b1, j[1:0]} + 4'd4][3:0]};
      mm = {s[{1'b0, j[1:0]} + 3'd4][7:6], s[{1'b1, j[1:0]} + 4'd4][7:4]};
    end
    return {sc, mm};
  endfunction

  // Half value as integer significand times a power of two.
  function automatic logic [10:0] half_sig(logic [15:0] h);
    return (h[14:10] == 5'd0) ? {1'b0, h[9:0]} : {1'b1, h[9:0]};
  endfunction

  function automatic logic signed [7:0] half_exp(logic [15:0] h);
    return (h[14:10] == 5'd0) ? -8'sd24 : $signed({3'b000, h[14:10]}) - 8'sd25;
  endfunction

  function automatic logic half_nan(logic [15:0] h);
    return (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
  endfunction

  function automatic logic half_inf(logic [15:0] h);
    return (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
  endfunction

  // Single-precision image of a half NaN with the quiet bit set.
  function automatic logic [31:0] half_qnan(logic [15:0] h);
    return {h[15], 8'hFF, 1'b1, h[8:0], 13'd0};
  endfunction

endpackage

// File: design/q4k_if.sv
`timescale 1ns / 1ps

interface q4k_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic        first_word;

  modport source (output valid, output data_word, output first_word, input ready);
  modport sink (input valid, input data_word, input first_word, output ready);
endinterface

interface q4k_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  first_position;
  logic [31:0] value_0;
  logic [31:0] value_1;
  logic [31:0] value_2;
  logic [31:0] value_3;
  logic [31:0] value_4;
  logic [31:0] value_5;
  logic [31:0] value_6;
  logic [31:0] value_7;
  logic        block_done;

  modport source (output valid, output first_position, output value_0, output value_1,
                  output value_2, output value_3, output value_4, output value_5,
                  output value_6, output value_7, output block_done, input ready);
  modport sink (input valid, input first_position, input value_0, input value_1,
                input value_2, input value_3, input value_4, input value_5,
                input value_6, input value_7, input block_done, output ready);
endinterface

// File: design/q4k_front.sv
`timescale 1ns / 1ps

module q4k_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  q4k_in_if.sink                in_i,
  input  q4k_pkg::fifo_status_t fifo_stat_i,
  output logic                  push_o,
  output q4k_pkg::job_t         job_o
);

  logic [4:0] pos_q, pos_d, pos;
  q4k_pkg::scale_t scale_q;
  logic [15:0] d_q, dmin_q;
  logic accept;
  logic [7:0] b;
  logic [1:0] c;
  logic [11:0] codes_lo, codes_hi;

  assign in_i.ready = !fifo_stat_i.full;
  assign accept = in_i.valid && in_i.ready;

  always_comb begin
    pos = in_i.first_word ? 5'd0 : pos_q;
    if (pos > q4k_pkg::LastPos) pos = 5'd0;
    pos_d = (pos == q4k_pkg::LastPos) ? 5'd0 : pos + 5'd1;
  end

  assign b = {pos - 5'd2, 3'b000};
  assign c = b[6:5];
  assign codes_lo = q4k_pkg::sub_codes(scale_q, {c, 1'b0});
  assign codes_hi = q4k_pkg::sub_codes(scale_q, {c, 1'b1});

  assign push_o = accept && (pos >= 5'd2);

  always_comb begin
    job_o.word      = in_i.data_word;
    job_o.d_half    = d_q;
    job_o.dmin_half = dmin_q;
    job_o.sc_lo     = codes_lo[11:6];
    job_o.mm_lo     = codes_lo[5:0];
    job_o.sc_hi     = codes_hi[11:6];
    job_o.mm_hi     = codes_hi[5:0];
    job_o.pos_lo    = {c, 1'b0, b[4:0]};
    job_o.last      = (pos == q4k_pkg::LastPos);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 5'd0;
    end else if (accept) begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pos == 5'd0) begin
      d_q    <= in_i.data_word[15:0];
      dmin_q <= in_i.data_word[31:16];
      for (int k = 0; k < 4; k++) scale_q[k] <= in_i.data_word[32 + 8*k +: 8];
    end else if (accept && pos == 5'd1) begin
      for (int k = 0; k < 8; k++) scale_q[4 + k] <= in_i.data_word[8*k +: 8];
    end
  end

endmodule

// File: design/q4k_fifo.sv
`timescale 1ns / 1ps

module q4k_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  q4k_pkg::job_t         job_i,
  input  logic                  pop_i,
  output q4k_pkg::job_t         job_o,
  output q4k_pkg::fifo_status_t stat_o
);

  q4k_pkg::job_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);
  assign job_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= job_i;
  end

endmodule

// File: design/q4k_back.sv
`timescale 1ns / 1ps

module q4k_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  q4k_pkg::fifo_status_t fifo_stat_i,
  input  q4k_pkg::job_t         job_i,
  output logic                  pop_o,
  q4k_out_if.source             out_o
);

  localparam logic [2:0] StProd = 3'd0;
  localparam logic [2:0] StLane = 3'd1;
  localparam logic [2:0] StAlign = 3'd2;
  localparam logic [2:0] StLzc = 3'd3;
  localparam logic [2:0] StPack = 3'd4;

  q4k_pkg::job_t cur_q;
  logic       busy_q, half_q;
  logic [2:0] step_q;

  logic [16:0] d1i_q, m1i_q;
  logic [3:0]  nib_q [8];
  logic [20:0] p_q [8];
  logic signed [7:0] e0_q;
  logic [50:0] mag_q [8];
  logic        neg_q [8];
  logic [5:0]  msb_q [8];

  logic        out_valid_q;
  logic [7:0]  out_pos_q;
  logic        out_done_q;
  logic [31:0] val_q [8];

  logic [5:0] sc, mm;
  logic signed [7:0] ed, em, e0;
  logic [4:0] shp, shq;
  logic can_load;
  logic [31:0] val_d [8];

  assign sc = half_q ? cur_q.sc_hi : cur_q.sc_lo;
  assign mm = half_q ? cur_q.mm_hi : cur_q.mm_lo;
  assign ed = q4k_pkg::half_exp(cur_q.d_half);
  assign em = q4k_pkg::half_exp(cur_q.dmin_half);
  assign e0 = (ed < em) ? ed : em;
  assign shp = 5'(ed - e0);
  assign shq = 5'(em - e0);

  assign can_load = !out_valid_q || out_o.ready;
  assign pop_o = !busy_q && !fifo_stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      half_q <= 1'b0;
      step_q <= StProd;
      out_valid_q <= 1'b0;
    end else begin
      if (busy_q && step_q == StPack && can_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (pop_o) begin
        busy_q <= 1'b1;
        half_q <= 1'b0;
        step_q <= StProd;
      end else if (busy_q) begin
        if (step_q != StPack) begin
          step_q <= step_q + 3'd1;
        end else if (can_load) begin
          step_q <= StProd;
          if (!half_q) half_q <= 1'b1;
          else busy_q <= 1'b0;
        end
      end
    end
  end

  // Finite path: every product is exact, so only the final subtraction rounds.
  always_ff @(posedge clk_i) begin
    logic [50:0] a, b;
    logic signed [51:0] diff;
    logic [5:0] lead;
    if (pop_o) cur_q <= job_i;
    if (busy_q) begin
      case (step_q)
        StProd: begin
          d1i_q <= 17'(q4k_pkg::half_sig(cur_q.d_half) * sc);
          m1i_q <= 17'(q4k_pkg::half_sig(cur_q.dmin_half) * mm);
          e0_q <= e0;
          for (int k = 0; k < 8; k++)
            nib_q[k] <= half_q ? cur_q.word[8*k+4 +: 4] : cur_q.word[8*k +: 4];
        end
        StLane: begin
          for (int k = 0; k < 8; k++) p_q[k] <= 21'(d1i_q * nib_q[k]);
        end
        StAlign: begin
          for (int k = 0; k < 8; k++) begin
            a = {30'd0, p_q[k]} << shp;
            b = {34'd0, m1i_q} << shq;
            diff = (cur_q.d_half[15] ? -$signed({1'b0, a}) : $signed({1'b0, a}))
                 - (cur_q.dmin_half[15] ? -$signed({1'b0, b}) : $signed({1'b0, b}));
            neg_q[k] <= diff[51];
            mag_q[k] <= diff[51] ? 51'(-diff) : diff[50:0];
          end
        end
        StLzc: begin
          for (int k = 0; k < 8; k++) begin
            lead = 6'd0;
            for (int i = 0; i < 51; i++) if (mag_q[k][i]) lead = 6'(i);
            msb_q[k] <= lead;
          end
        end
        default: ;
      endcase
    end
    if (busy_q && step_q == StPack && can_load) begin
      out_pos_q  <= half_q ? cur_q.pos_lo + 8'd32 : cur_q.pos_lo;
      out_done_q <= half_q && cur_q.last;
      for (int k = 0; k < 8; k++) val_q[k] <= val_d[k];
    end
  end

  always_comb begin
    logic sd, sm, pnan, pinf, mnan, minf;
    logic [31:0] pbits, mbits, fin;
    logic [5:0] sh;
    logic [50:0] kept, smask;
    logic guard, sticky;
    logic [24:0] rnd;
    logic [9:0] ex;
    sd = cur_q.d_half[15];
    sm = cur_q.dmin_half[15];
    for (int k = 0; k < 8; k++) begin
      pnan = 1'b0; pinf = 1'b0; pbits = 32'd0;
      if (q4k_pkg::half_nan(cur_q.d_half)) begin
        pnan = 1'b1; pbits = q4k_pkg::half_qnan(cur_q.d_half);
      end else if (q4k_pkg::half_inf(cur_q.d_half)) begin
        if (sc == 6'd0 || nib_q[k] == 4'd0) begin
          pnan = 1'b1; pbits = q4k_pkg::DefaultNan;
        end else begin
          pinf = 1'b1; pbits = {sd, 8'hFF, 23'd0};
        end
      end
      mnan = 1'b0; minf = 1'b0; mbits = 32'd0;
      if (q4k_pkg::half_nan(cur_q.dmin_half)) begin
        mnan = 1'b1; mbits = q4k_pkg::half_qnan(cur_q.dmin_half);
      end else if (q4k_pkg::half_inf(cur_q.dmin_half)) begin
        if (mm == 6'd0) begin
          mnan = 1'b1; mbits = q4k_pkg::DefaultNan;
        end else begin
          minf = 1'b1; mbits = {sm, 8'hFF, 23'd0};
        end
      end
      // Round the finite difference to nearest even.
      sh = msb_q[k] - 6'd23;
      kept = mag_q[k] >> sh;
      guard = 1'b0; sticky = 1'b0;
      if (msb_q[k] > 6'd23) begin
        guard = mag_q[k][sh - 6'd1];
        smask = (51'd1 << (sh - 6'd1)) - 51'd1;
        sticky = |(mag_q[k] & smask);
        rnd = {1'b0, kept[23:0]} + {24'd0, guard & (sticky | kept[0])};
      end else begin
        smask = mag_q[k] << (6'd23 - msb_q[k]);
        rnd = {1'b0, smask[23:0]};
      end
      ex = 10'($signed(e0_q) + $signed({4'd0, msb_q[k]}) + 10'sd127) + {9'd0, rnd[24]};
      if (mag_q[k] == 51'd0)
        fin = {(p_q[k] == 21'd0 && m1i_q == 17'd0) ? (sd & ~sm) : 1'b0, 31'd0};
      else
        fin = {neg_q[k], ex[7:0], rnd[24] ? 23'd0 : rnd[22:0]};
      if (pnan) val_d[k] = pbits;
      else if (mnan) val_d[k] = mbits;
      else if (pinf) val_d[k] = (minf && sm == sd) ? q4k_pkg::DefaultNan : pbits;
      else if (minf) val_d[k] = {~sm, 8'hFF, 23'd0};
      else val_d[k] = fin;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.first_position = out_pos_q;
  assign out_o.block_done = out_done_q;
  assign out_o.value_0 = val_q[0];
  assign out_o.value_1 = val_q[1];
  assign out_o.value_2 = val_q[2];
  assign out_o.value_3 = val_q[3];
  assign out_o.value_4 = val_q[4];
  assign out_o.value_5 = val_q[5];
  assign out_o.value_6 = val_q[6];
  assign out_o.value_7 = val_q[7];

endmodule

// File: design/q4k_block_dequantizer_top.sv
`timescale 1ns / 1ps
// Header words 0 and 1 produce no results.
// A nibble word gives two results of eight values; the back end pops it from the queue and
// runs each result through its steps: product, lane, align, leading-zero count and pack.
// Pack holds while the output is stalled; a two-entry queue lets the front keep taking
// words while the back end works. Reset clears position, queue and valid flags.
module q4k_block_dequantizer_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  q4k_in_if.sink    in_i,
  q4k_out_if.source out_o
);

  q4k_pkg::fifo_status_t fstat;
  q4k_pkg::job_t job_in, job_out;
  logic push, pop;

  q4k_front u_front (
    .clk_i, .rst_ni, .in_i, .fifo_stat_i(fstat), .push_o(push), .job_o(job_in)
  );

  q4k_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .job_i(job_in), .pop_i(pop), .job_o(job_out),
    .stat_o(fstat)
  );

  q4k_back u_back (
    .clk_i, .rst_ni, .fifo_stat_i(fstat), .job_i(job_out), .pop_o(pop), .out_o
  );

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.full |-> !push) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fstat.empty |-> !pop) else $error("queue underflow");
  a_done_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.block_done) |-> (out_o.first_position == 8'd248))
    else $error("block end at wrong position");
`endif

endmodule

// File: bench/tb_q4k_block_dequantizer_top.sv
`timescale 1ns / 1ps

module tb_q4k_block_dequantizer_top;

  localparam int unsigned ItemTarget = 1550;
  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned HoldOffCycles = 300;
  localparam logic [31:0] PosInf = 32'h7F800000;
  localparam logic [31:0] QuietBit = 32'h00400000;

  typedef struct packed {
    logic [7:0]       pos;
    logic [7:0][31:0] vals;
    logic             done;
  } deq_row_t;

  typedef struct {
    logic [63:0] word;
    logic        first;
    logic        typed;
    logic [31:0] value;
  } stim_row_t;

  logic clk;
  logic rst_n;
  q4k_in_if  in_bus ();
  q4k_out_if out_bus ();

  q4k_block_dequantizer_top u_dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // Mirror of the block state.
  logic [4:0]       blk_pos;
  q4k_pkg::scale_t  blk_scales;
  logic [15:0]      blk_d;
  logic [15:0]      blk_dmin;

  deq_row_t    pending_rows[$];
  stim_row_t   directed_rows[$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned cycles;
  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  bit          hold_off_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("q4k_block_dequantizer_top: mismatch");
      $finish;
    end
  end

  task automatic flag_mismatch(input string msg);
    $display("ERROR %0t: %s", $time, msg);
    mismatches++;
  endtask

  // ---- fp32 helpers: exact products and differences in double, then one rounding.
  function automatic logic is_nan(logic [31:0] a);
    return (a[30:23] == 8'hFF) && (a[22:0] != 0);
  endfunction

  function automatic logic is_inf(logic [31:0] a);
    return (a[30:0] == PosInf[30:0]);
  endfunction

  function automatic real f32_to_real(logic [31:0] a);
    logic [10:0] e;
    if (a[30:0] == 0) return $bitstoreal({a[31], 63'd0});
    e = 11'(int'(a[30:23]) - 127 + 1023);
    return $bitstoreal({a[31], e, a[22:0], 29'd0});
  endfunction

  // Round a double to the nearest even fp32; results here never leave the normal range.
  function automatic logic [31:0] real_to_f32(real x);
    logic [63:0] b;
    logic [23:0] m;
    logic [28:0] rest;
    int          e;
    b = $realtobits(x);
    if (b[62:0] == 0) return {b[63], 31'd0};
    e = int'(b[62:52]) - 1023 + 127;
    m = {1'b0, b[51:29]};
    rest = b[28:0];
    if (rest > 29'h10000000 || (rest == 29'h10000000 && m[0])) m = m + 1;
    if (m[23]) begin
      m = 0;
      e = e + 1;
    end
    return {b[63], 8'(e), m[22:0]};
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    if (is_nan(a)) return a | QuietBit;
    if (is_nan(b)) return b | QuietBit;
    if (is_inf(a) || is_inf(b)) begin
      if (a[30:0] == 0 || b[30:0] == 0) return q4k_pkg::DefaultNan;
      return {a[31] ^ b[31], PosInf[30:0]};
    end
    return real_to_f32(f32_to_real(a) * f32_to_real(b));
  endfunction

  function automatic logic [31:0] fp_sub(logic [31:0] a, logic [31:0] b);
    if (is_nan(a)) return a | QuietBit;
    if (is_nan(b)) return b | QuietBit;
    if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? q4k_pkg::DefaultNan : a;
    if (is_inf(a)) return a;
    if (is_inf(b)) return {~b[31], b[30:0]};
    return real_to_f32(f32_to_real(a) - f32_to_real(b));
  endfunction

  function automatic logic [31:0] half_to_f32(logic [15:0] h);
    logic [9:0]  man;
    logic [10:0] sig;
    int          e;
    man = h[9:0];
    if (h[14:10] == 0) begin
      if (man == 0) return {h[15], 31'd0};
      // Subnormal halves become normal singles.
      sig = {1'b0, man};
      e = 127 - 15 + 1;
      while (!sig[10]) begin
        sig = sig << 1;
        e--;
      end
      return {h[15], 8'(e), sig[9:0], 13'd0};
    end
    if (h[14:10] == 5'h1F) return {h[15], 8'hFF, man, 13'd0};
    return {h[15], 8'(int'(h[14:10]) + 127 - 15), man, 13'd0};
  endfunction

  function automatic deq_row_t dequant_half(logic [63:0] w, int unsigned j, int unsigned shift,
                                            int unsigned pos, logic done);
    deq_row_t    r;
    int unsigned sc;
    int unsigned mm;
    logic [31:0] d1;
    logic [31:0] m1;
    if (j < 4) begin
      sc = blk_scales[j] & 63;
      mm = blk_scales[j + 4] & 63;
    end else begin
      sc = (blk_scales[j + 4] & 4'hF) | ((blk_scales[j - 4] >> 6) << 4);
      mm = (blk_scales[j + 4] >> 4) | ((blk_scales[j] >> 6) << 4);
    end
    d1 = fp_mul(half_to_f32(blk_d), real_to_f32(real'(sc)));
    m1 = fp_mul(half_to_f32(blk_dmin), real_to_f32(real'(mm)));
    r.pos = 8'(pos);
    for (int k = 0; k < 8; k++)
      r.vals[k] = fp_sub(fp_mul(d1, real_to_f32(real'((w >> (8 * k + shift)) & 4'hF))), m1);
    r.done = done;
    return r;
  endfunction

  // Updates the mirrored state for one word and queues the rows it yields.
  function automatic int dequant_word(logic [63:0] w, logic first);
    int unsigned p;
    int unsigned b;
    int unsigned c;
    int unsigned l;
    int          n;
    n = 0;
    p = first ? 0 : blk_pos;
    if (p >= q4k_pkg::BlockWords) p = 0;
    if (p == 0) begin
      blk_d = w[15:0];
      blk_dmin = w[31:16];
      for (int k = 0; k < 4; k++) blk_scales[k] = w[32 + 8 * k +: 8];
    end else if (p == 1) begin
      for (int k = 0; k < 8; k++) blk_scales[4 + k] = w[8 * k +: 8];
    end else begin
      b = (p - 2) * 8;
      c = b >> 5;
      l = b & 31;
      pending_rows.push_back(dequant_half(w, 2 * c, 0, 64 * c + l, 1'b0));
      pending_rows.push_back(dequant_half(w, 2 * c + 1, 4, 64 * c + 32 + l,
                                          p == q4k_pkg::LastPos));
      n = 2;
    end
    p++;
    if (p >= q4k_pkg::BlockWords) p = 0;
    blk_pos = 5'(p);
    return n;
  endfunction

  // ---- sender
  task automatic send_word(input logic [63:0] w, input logic first, output int n);
    if ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.data_word  <= w;
    in_bus.first_word <= first;
    do @(posedge clk); while (!in_bus.ready);
    n = dequant_word(w, first);
    items_sent++;
  endtask

  function automatic logic [15:0] pick_half();
    logic [15:0] odd_halves[12] = '{16'h0000, 16'h8000, 16'h0001, 16'h03FF, 16'h7BFF, 16'hFBFF,
                                    16'h7C00, 16'hFC00, 16'h7E00, 16'h7D55, 16'hFE01, 16'h3C00};
    if ($urandom_range(99) < 15) return odd_halves[$urandom_range(11)];
    return 16'($urandom);
  endfunction

  task automatic send_random_block();
    int unsigned kind;
    int unsigned len;
    int          n;
    kind = $urandom_range(99);
    if (kind < 90) begin
      // Well-formed header, full block or cut short by the next mark.
      len = (kind < 78) ? q4k_pkg::BlockWords : $urandom_range(q4k_pkg::BlockWords - 1, 1);
      send_word({32'($urandom), pick_half(), pick_half()},
                (blk_pos == 0) ? logic'($urandom_range(99) >= 8) : 1'b1, n);
      for (int i = 1; i < len; i++) send_word({32'($urandom), 32'($urandom)}, 1'b0, n);
    end else begin
      len = $urandom_range(5, 1);
      for (int i = 0; i < len; i++)
        send_word({32'($urandom), 32'($urandom)}, logic'($urandom_range(1)), n);
    end
  endtask

  task automatic add_row(input logic [63:0] w, input logic first, input logic typed = 1'b0,
                         input logic [31:0] value = 32'd0);
    stim_row_t r;
    r.word = w;
    r.first = first;
    r.typed = typed;
    r.value = value;
    directed_rows.push_back(r);
  endtask

  // ---- receiver
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_bus.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // ---- checker
  always @(posedge clk) begin
    deq_row_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_rows.size() == 0) begin
        flag_mismatch($sformatf("unexpected transaction at position %0d",
                                out_bus.first_position));
      end else begin
        want = pending_rows.pop_front();
        if (out_bus.first_position !== want.pos)
          flag_mismatch($sformatf("first_position %0d, expected %0d",
                                  out_bus.first_position, want.pos));
        if (out_bus.value_0 !== want.vals[0])
          flag_mismatch($sformatf("pos %0d value_0 %h, expected %h", want.pos,
                                  out_bus.value_0, want.vals[0]));
        if (out_bus.value_1 !== want.vals[1])
          flag_mismatch($sformatf("pos %0d value_1 %h, expected %h", want.pos,
                                  out_bus.value_1, want.vals[1]));
        if (out_bus.value_2 !== want.vals[2])
          flag_mismatch($sformatf("pos %0d value_2 %h, expected %h", want.pos,
                                  out_bus.value_2, want.vals[2]));
        if (out_bus.value_3 !== want.vals[3])
          flag_mismatch($sformatf("pos %0d value_3 %h, expected %h", want.pos,
                                  out_bus.value_3, want.vals[3]));
        if (out_bus.value_4 !== want.vals[4])
          flag_mismatch($sformatf("pos %0d value_4 %h, expected %h", want.pos,
                                  out_bus.value_4, want.vals[4]));
        if (out_bus.value_5 !== want.vals[5])
          flag_mismatch($sformatf("pos %0d value_5 %h, expected %h", want.pos,
                                  out_bus.value_5, want.vals[5]));
        if (out_bus.value_6 !== want.vals[6])
          flag_mismatch($sformatf("pos %0d value_6 %h, expected %h", want.pos,
                                  out_bus.value_6, want.vals[6]));
        if (out_bus.value_7 !== want.vals[7])
          flag_mismatch($sformatf("pos %0d value_7 %h, expected %h", want.pos,
                                  out_bus.value_7, want.vals[7]));
        if (out_bus.block_done !== want.done)
          flag_mismatch($sformatf("pos %0d block_done %b, expected %b", want.pos,
                                  out_bus.block_done, want.done));
      end
    end
  end

  // ---- main sequence
  initial begin
    int n;
    int unsigned phase;
    mismatches = 0;
    items_sent = 0;
    cycles = 0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_off_req = 1'b0;
    blk_pos = '0;
    blk_scales = '0;
    blk_d = '0;
    blk_dmin = '0;
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.data_word <= '0;
    in_bus.first_word <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unit scales, zero minimum: nibbles come out as plain integers.
    add_row(64'h01010101_00003C00, 1'b1);
    add_row(64'h01010101_00000000, 1'b0);
    add_row(64'hFFFFFFFF_FFFFFFFF, 1'b0, 1'b1, 32'h41700000);
    add_row(64'h00000000_00000000, 1'b0, 1'b1, 32'h00000000);
    // Mark in mid-block with infinite scale and NaN minimum.
    add_row(64'hFFFFFFFF_7E017C00, 1'b1);
    add_row(64'hFFFFFFFF_FFFFFFFF, 1'b0);
    add_row(64'hFFFFFFFF_FFFFFFFF, 1'b0);
    add_row(64'h01234567_89ABCDEF, 1'b0);
    // Full block with a subnormal scale and the most negative minimum, then the
    // word after the block end arrives without a mark.
    add_row(64'hC0FF3F80_FBFF0001, 1'b1);
    add_row(64'h5AA5FF00_3FC0E7F1, 1'b0);
    for (int i = 0; i < 16; i++) add_row({32'($urandom), 32'($urandom)}, 1'b0);
    add_row(64'h3F3F3F3F_00007BFF, 1'b0);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].first, n);
      if (directed_rows[i].typed)
        for (int k = pending_rows.size() - n; k < pending_rows.size(); k++)
          pending_rows[k].vals = {8{directed_rows[i].value}};
    end

    hold_off_req = 1'b1;
    while (items_sent < ItemTarget) begin
      phase = items_sent * 4 / ItemTarget;
      case (phase)
        0: begin
          src_idle_pct = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 70;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          snk_stall_pct = 70;
        end
        default: begin
          src_idle_pct = 24;
          snk_stall_pct = 24;
        end
      endcase
      send_random_block();
    end
    in_bus.valid <= 1'b0;

    while (pending_rows.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("q4k_block_dequantizer_top: match");
    end else begin
      $display("q4k_block_dequantizer_top: mismatch");
    end
    $finish;
  end

endmodule
